// File: hw/rtl/wcl_pkg.sv
package wcl_pkg;

  // Chunk tags as they arrive, first byte in the top bits
  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam int unsigned CFG_W = 27;
  localparam logic [CFG_W-1:0] MAX_BYTES_RESET = 27'h4000000;

  // Smallest legal file and smallest legal fmt payload
  localparam logic [32:0] MIN_FILE_BYTES = 33'd12;
  localparam logic [31:0] MIN_FMT_BYTES  = 32'd16;

  localparam int unsigned OFS_W = 26;
  localparam int unsigned LEN_W = 27;
  localparam int unsigned OUT_W = 112;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_LENGTH     = 3'd1,
    ST_TAGS       = 3'd2,
    ST_OVERRUN    = 3'd3,
    ST_FMT_BAD    = 3'd4,
    ST_AUDIO_BAD  = 3'd5
  } status_t;

  // One input byte as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result, packed from the top field down to status at bit 0
  typedef struct packed {
    logic [LEN_W-1:0] audio_bytes;
    logic [OFS_W-1:0] audio_offset;
    logic [LEN_W-1:0] fmt_length;
    logic [OFS_W-1:0] fmt_offset;
    status_t          status;
  } result_t;

endpackage

// File: hw/rtl/wcl_in_reg.sv
module wcl_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output logic          item_valid,
  output wcl_pkg::item_t item,
  input  logic          take
);
  import wcl_pkg::*;

  logic  valid_r;
  item_t item_r;

  // Accept a new request when the register is empty or the held one leaves this cycle
  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data_byte <= in_tdata;
      item_r.last_byte <= in_tlast;
    end
  end

endmodule

// File: hw/rtl/wcl_parser.sv
module wcl_parser #(
  parameter int unsigned POSITION_BITS = 27
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [26:0]          cfg_data,
  input  logic                 item_valid,
  input  wcl_pkg::item_t       item,
  input  logic                 out_space,
  output logic                 take,
  output logic                 fire,
  output wcl_pkg::result_t     res
);
  import wcl_pkg::*;

  localparam int unsigned PW = POSITION_BITS;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  typedef enum logic [1:0] {
    PH_FILE = 2'd0,
    PH_HDR  = 2'd1,
    PH_PAY  = 2'd2,
    PH_PAD  = 2'd3
  } phase_t;

  logic [CFG_W-1:0] max_r;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic             over_r, over_nxt;
  phase_t           phase_r, phase_nxt;
  logic [2:0]       hidx_r, hidx_nxt;
  logic [31:0]      tag_r, tag_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [31:0]      left_r, left_nxt;
  logic             pad_r, pad_nxt;
  logic             fmt_seen_r, fmt_seen_nxt;
  logic [PW-1:0]    fmt_start_r, fmt_start_nxt;
  logic [31:0]      fmt_size_r, fmt_size_nxt;
  logic             aud_seen_r, aud_seen_nxt;
  logic [PW-1:0]    aud_start_r, aud_start_nxt;
  logic [31:0]      aud_size_r, aud_size_nxt;
  logic             bad_r, bad_nxt;
  logic             ovr_r, ovr_nxt;

  logic [32:0]      len;
  logic [31:0]      fmt_start_ext;
  logic [31:0]      aud_start_ext;
  status_t          status;

  // A last byte waits for a free output slot; other bytes always pass
  assign take = item_valid && (!item.last_byte || out_space);
  assign fire = take && item.last_byte;

  assign len           = 33'(pos_r) + 33'd1;
  assign fmt_start_ext = 32'(fmt_start_nxt);
  assign aud_start_ext = 32'(aud_start_nxt);

  // Advance the parse by one byte
  always_comb begin
    pos_nxt       = pos_r;
    over_nxt      = over_r;
    phase_nxt     = phase_r;
    hidx_nxt      = hidx_r;
    tag_nxt       = tag_r;
    size_nxt      = size_r;
    left_nxt      = left_r;
    pad_nxt       = pad_r;
    fmt_seen_nxt  = fmt_seen_r;
    fmt_start_nxt = fmt_start_r;
    fmt_size_nxt  = fmt_size_r;
    aud_seen_nxt  = aud_seen_r;
    aud_start_nxt = aud_start_r;
    aud_size_nxt  = aud_size_r;
    bad_nxt       = bad_r;
    ovr_nxt       = ovr_r;
    if (pos_r == POS_MAX) begin
      over_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + PW'(1);
    end
    unique case (phase_r)
      PH_FILE: begin
        tag_nxt = {tag_r[23:0], item.data_byte};
        if (pos_r == PW'(3) && tag_nxt != TAG_RIFF) begin
          bad_nxt = 1'b1;
        end
        if (pos_r == PW'(11)) begin
          if (tag_nxt != TAG_WAVE) begin
            bad_nxt = 1'b1;
          end
          phase_nxt = PH_HDR;
          hidx_nxt  = 3'd0;
        end
      end
      PH_HDR: begin
        if (!hidx_r[2]) begin
          tag_nxt = {tag_r[23:0], item.data_byte};
        end else begin
          size_nxt = {item.data_byte, size_r[31:8]};
        end
        if (hidx_r == 3'd7) begin
          // Record the payload start, which is the next byte position
          if (tag_nxt == TAG_FMT) begin
            fmt_seen_nxt  = 1'b1;
            fmt_start_nxt = pos_r + PW'(1);
            fmt_size_nxt  = size_nxt;
          end else if (tag_nxt == TAG_DATA) begin
            aud_seen_nxt  = 1'b1;
            aud_start_nxt = pos_r + PW'(1);
            aud_size_nxt  = size_nxt;
          end
          left_nxt = size_nxt;
          pad_nxt  = size_nxt[0];
          hidx_nxt = 3'd0;
          phase_nxt = (size_nxt == 32'd0) ? PH_HDR : PH_PAY;
        end else begin
          hidx_nxt = hidx_r + 3'd1;
        end
      end
      PH_PAY: begin
        left_nxt = left_r - 32'd1;
        if (left_nxt == 32'd0) begin
          phase_nxt = pad_r ? PH_PAD : PH_HDR;
          hidx_nxt  = 3'd0;
        end
      end
      PH_PAD: begin
        pad_nxt   = 1'b0;
        phase_nxt = PH_HDR;
        hidx_nxt  = 3'd0;
      end
      default: begin
        phase_nxt = PH_HDR;
      end
    endcase
    // Flag a payload still open when the file ends
    if (item.last_byte && phase_nxt == PH_PAY && left_nxt != 32'd0) begin
      ovr_nxt = 1'b1;
    end
  end

  // Pick the first failing check
  always_comb begin
    priority if (over_nxt || len < MIN_FILE_BYTES || len > 33'(max_r)) begin
      status = ST_LENGTH;
    end else if (bad_nxt) begin
      status = ST_TAGS;
    end else if (ovr_nxt) begin
      status = ST_OVERRUN;
    end else if (!fmt_seen_nxt || fmt_size_nxt < MIN_FMT_BYTES) begin
      status = ST_FMT_BAD;
    end else if (!aud_seen_nxt || aud_size_nxt == 32'd0) begin
      status = ST_AUDIO_BAD;
    end else begin
      status = ST_OK;
    end
  end

  // Drive the offsets and lengths only for a good file
  always_comb begin
    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.fmt_offset   = fmt_start_ext[OFS_W-1:0];
      res.fmt_length   = fmt_size_nxt[LEN_W-1:0];
      res.audio_offset = aud_start_ext[OFS_W-1:0];
      res.audio_bytes  = aud_size_nxt[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_BYTES_RESET;
    end else if (cfg_valid) begin
      max_r <= cfg_data;
    end
  end

  // Hold the parse state; drop it after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n || fire) begin
      pos_r       <= '0;
      over_r      <= 1'b0;
      phase_r     <= PH_FILE;
      hidx_r      <= 3'd0;
      tag_r       <= '0;
      size_r      <= '0;
      left_r      <= '0;
      pad_r       <= 1'b0;
      fmt_seen_r  <= 1'b0;
      fmt_start_r <= '0;
      fmt_size_r  <= '0;
      aud_seen_r  <= 1'b0;
      aud_start_r <= '0;
      aud_size_r  <= '0;
      bad_r       <= 1'b0;
      ovr_r       <= 1'b0;
    end else if (take) begin
      pos_r       <= pos_nxt;
      over_r      <= over_nxt;
      phase_r     <= phase_nxt;
      hidx_r      <= hidx_nxt;
      tag_r       <= tag_nxt;
      size_r      <= size_nxt;
      left_r      <= left_nxt;
      pad_r       <= pad_nxt;
      fmt_seen_r  <= fmt_seen_nxt;
      fmt_start_r <= fmt_start_nxt;
      fmt_size_r  <= fmt_size_nxt;
      aud_seen_r  <= aud_seen_nxt;
      aud_start_r <= aud_start_nxt;
      aud_size_r  <= aud_size_nxt;
      bad_r       <= bad_nxt;
      ovr_r       <= ovr_nxt;
    end
  end

endmodule

// File: hw/rtl/wcl_out_reg.sv
module wcl_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  wcl_pkg::result_t     res,
  output logic                 space,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [111:0]         out_tdata
);
  import wcl_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign space      = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {(OUT_W - $bits(result_t))'(0), res_r};

  // Hold a result until taken; reload in the same cycle it leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      res_r <= res;
    end
  end

endmodule

// File: hw/rtl/wave_chunk_locator.sv
// Result: a last byte passes the input register, then its result is registered in the output register.
// Throughput: one byte per cycle; the only stall is a last byte waiting for the
// output register, which holds one finished status while the next file streams in.
// Reset: synchronous, active low; clears parse state and sets max_file_bytes to 2^26.
// After each last byte all parse state returns to its reset value; the limit is kept.
module wave_chunk_locator #(
  parameter int unsigned POSITION_BITS = 27
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], fmt_offset[28:3], fmt_length[55:29], audio_offset[81:56],
  // audio_bytes[108:82], zero fill [111:109]
  output logic [111:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [26:0]  cfg_data    // max_file_bytes
);
  import wcl_pkg::*;

  logic    item_valid;
  item_t   item;
  logic    take;
  logic    fire;
  logic    space;
  result_t res;

  assign cfg_ready = 1'b1;

  wcl_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  wcl_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_space  (space),
    .take       (take),
    .fire       (fire),
    .res        (res)
  );

  wcl_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hw/rtl/wcl_checker.sv
module wcl_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata
);
  import wcl_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Status stays within the defined codes
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_AUDIO_BAD)
    else $error("undefined status code");

  // An error result carries no offsets or lengths
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[111:3] == '0)
    else $error("error result with nonzero fields");

  // Nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind wave_chunk_locator wcl_checker u_wcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/wave_chunk_locator_tb.sv
`timescale 1ns / 100ps

module wave_chunk_locator_tb;
  import wcl_pkg::*;

  typedef enum logic [1:0] {
    PH_FILE_HDR,
    PH_CHUNK_HDR,
    PH_PAYLOAD,
    PH_PAD
  } parse_phase_t;

  // Tracks the chunk walk byte by byte and holds the status expected per file
  class chunk_scoreboard;
    logic [CFG_W-1:0] max_bytes;
    logic [26:0]      position;
    bit               count_over;
    parse_phase_t     phase;
    logic [2:0]       hdr_idx;
    logic [31:0]      tag_sr;
    logic [31:0]      size_sr;
    logic [31:0]      remaining;
    bit               pad_due;
    bit               fmt_found;
    bit               audio_found;
    bit               tags_bad;
    bit               overrun;
    logic [26:0]      fmt_start;
    logic [26:0]      audio_start;
    logic [31:0]      fmt_size;
    logic [31:0]      audio_size;
    result_t          want_status[$];
    int               errors;

    function new();
      max_bytes = MAX_BYTES_RESET;
      errors = 0;
      clear();
    endfunction

    function void clear();
      position = '0;
      count_over = 0;
      phase = PH_FILE_HDR;
      hdr_idx = '0;
      tag_sr = '0;
      size_sr = '0;
      remaining = '0;
      pad_due = 0;
      fmt_found = 0;
      audio_found = 0;
      tags_bad = 0;
      overrun = 0;
      fmt_start = '0;
      audio_start = '0;
      fmt_size = '0;
      audio_size = '0;
    endfunction

    function void finish_chunk();
      phase = pad_due ? PH_PAD : PH_CHUNK_HDR;
      hdr_idx = '0;
    endfunction

    function void take_byte(input logic [7:0] b, input logic last);
      logic [26:0] pos;
      logic [26:0] start;
      logic [27:0] len;
      status_t     st;
      result_t     r;
      pos = position;
      // Saturate the byte counter and remember the overflow
      if (pos == '1) count_over = 1;
      else position = pos + 27'd1;
      case (phase)
        PH_FILE_HDR: begin
          tag_sr = {tag_sr[23:0], b};
          if (pos == 27'd3 && tag_sr != TAG_RIFF) tags_bad = 1;
          if (pos == 27'd11) begin
            if (tag_sr != TAG_WAVE) tags_bad = 1;
            phase = PH_CHUNK_HDR;
            hdr_idx = '0;
          end
        end
        PH_CHUNK_HDR: begin
          if (hdr_idx < 3'd4) tag_sr = {tag_sr[23:0], b};
          else size_sr = {b, size_sr[31:8]};
          if (hdr_idx == 3'd7) begin
            start = pos + 27'd1;
            if (tag_sr == TAG_FMT) begin
              fmt_found = 1;
              fmt_start = start;
              fmt_size = size_sr;
            end else if (tag_sr == TAG_DATA) begin
              audio_found = 1;
              audio_start = start;
              audio_size = size_sr;
            end
            remaining = size_sr;
            pad_due = size_sr[0];
            if (remaining == 0) finish_chunk();
            else phase = PH_PAYLOAD;
          end else begin
            hdr_idx = hdr_idx + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          remaining = remaining - 32'd1;
          if (remaining == 0) finish_chunk();
        end
        default: begin
          pad_due = 0;
          phase = PH_CHUNK_HDR;
          hdr_idx = '0;
        end
      endcase
      if (!last) return;

      // Grade the finished file, first failing check wins
      if (phase == PH_PAYLOAD && remaining != 0) overrun = 1;
      len = {1'b0, pos} + 28'd1;
      if (count_over || len < MIN_FILE_BYTES || len > {1'b0, max_bytes}) st = ST_LENGTH;
      else if (tags_bad) st = ST_TAGS;
      else if (overrun) st = ST_OVERRUN;
      else if (!fmt_found || fmt_size < MIN_FMT_BYTES) st = ST_FMT_BAD;
      else if (!audio_found || audio_size == 0) st = ST_AUDIO_BAD;
      else st = ST_OK;
      r = '0;
      r.status = st;
      if (st == ST_OK) begin
        r.fmt_offset = fmt_start[OFS_W-1:0];
        r.fmt_length = fmt_size[LEN_W-1:0];
        r.audio_offset = audio_start[OFS_W-1:0];
        r.audio_bytes = audio_size[LEN_W-1:0];
      end
      want_status.push_back(r);
      clear();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("%0t MISMATCH %s", $time, msg);
    endtask

    task check_status(input logic [OUT_W-1:0] word);
      result_t got;
      result_t want;
      got = word[108:0];
      if (want_status.size() == 0) begin
        report($sformatf("result with no pending request, status %0d", got.status));
        return;
      end
      want = want_status.pop_front();
      if (got.status != want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.fmt_offset != want.fmt_offset)
        report($sformatf("fmt_offset got %0d want %0d", got.fmt_offset, want.fmt_offset));
      if (got.fmt_length != want.fmt_length)
        report($sformatf("fmt_length got %0d want %0d", got.fmt_length, want.fmt_length));
      if (got.audio_offset != want.audio_offset)
        report($sformatf("audio_offset got %0d want %0d",
                         got.audio_offset, want.audio_offset));
      if (got.audio_bytes != want.audio_bytes)
        report($sformatf("audio_bytes got %0d want %0d",
                         got.audio_bytes, want.audio_bytes));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  chunk_scoreboard   sb;
  logic [7:0]        wav_image[$];
  bit                last_pad;
  bit                steady = 0;
  int                stall_req = 0;
  int                sent_bytes = 0;

  wave_chunk_locator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the block hangs
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random backpressure, plus a long hold when requested
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (stall_req != 0) begin
        hold = stall_req;
        stall_req = 0;
        repeat (hold) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
      end
      out_tready <= steady || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_byte(b, last);
  endtask

  task automatic send_file();
    if (wav_image.size() == 0) wav_image.push_back(8'($urandom));
    foreach (wav_image[i]) send_byte(wav_image[i], i == wav_image.size() - 1);
    sent_bytes += wav_image.size();
  endtask

  // Drop valid and wait out every pending status plus the output latency
  task automatic drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.want_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CFG_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.max_bytes = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic add_word(input logic [31:0] w, input bit little);
    for (int i = 0; i < 4; i++)
      wav_image.push_back(little ? w[8*i +: 8] : w[8*(3-i) +: 8]);
  endtask

  task automatic add_body(input int unsigned n);
    repeat (n) wav_image.push_back(8'($urandom));
  endtask

  task automatic begin_file();
    wav_image.delete();
    add_word(TAG_RIFF, 0);
    add_word($urandom, 1);
    add_word(TAG_WAVE, 0);
  endtask

  // Full chunk: header, payload, pad byte on odd size
  task automatic add_chunk(input logic [31:0] tag, input int unsigned size);
    add_word(tag, 0);
    add_word(size, 1);
    add_body(size);
    last_pad = size[0];
    if (last_pad) add_body(1);
  endtask

  task automatic build_random_file();
    int shape;
    int sel;
    int idx;
    shape = $urandom_range(99);
    if (shape < 10) begin
      // Plain noise
      wav_image.delete();
      add_body($urandom_range(1, 40));
      return;
    end
    begin_file();
    last_pad = 0;
    repeat ($urandom_range(0, 4)) begin
      sel = $urandom_range(99);
      if (sel < 40)
        add_chunk(TAG_FMT, ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(16, 20));
      else if (sel < 75)
        add_chunk(TAG_DATA, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24));
      else
        add_chunk($urandom, $urandom_range(8));
    end
    // Damage some files in one of several ways
    if (shape < 18) begin
      idx = $urandom_range(7);
      if (idx >= 4) idx += 4;
      wav_image[idx] ^= 8'(1 << $urandom_range(7));
    end else if (shape < 28) begin
      if (last_pad) void'(wav_image.pop_back());
    end else if (shape < 38) begin
      add_body($urandom_range(1, 7));
    end else if (shape < 48) begin
      repeat ($urandom_range(1, 10))
        if (wav_image.size() > 1) void'(wav_image.pop_back());
    end else if (shape < 54) begin
      add_word(TAG_DATA, 0);
      add_word($urandom | 32'h100, 1);
      add_body($urandom_range(0, 6));
    end
  endtask

  task automatic send_random_files(input int n);
    repeat (n) begin
      build_random_file();
      send_file();
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: clean file, multiple chunks and missing final pad
    set_limit(MAX_BYTES_RESET);
    begin_file(); add_chunk(TAG_FMT, 16); add_chunk(TAG_DATA, 1); send_file();
    begin_file(); add_chunk(TAG_FMT, 18); add_chunk(32'h4C495354, 3);
    add_chunk(TAG_DATA, 5); add_chunk(TAG_FMT, 16); add_chunk(TAG_DATA, 7);
    void'(wav_image.pop_back()); send_file();
    // Partial trailing chunk header
    begin_file(); add_chunk(TAG_FMT, 16); add_chunk(TAG_DATA, 2); add_body(5); send_file();
    // Too short: eleven bytes, then a lone last byte
    begin_file(); void'(wav_image.pop_back()); send_file();
    wav_image.delete(); wav_image.push_back(8'hFF); send_file();
    // Bad RIFF tag, bad WAVE tag
    begin_file(); wav_image[0] = 8'h72; add_chunk(TAG_FMT, 16); add_chunk(TAG_DATA, 4);
    send_file();
    begin_file(); wav_image[11] ^= 8'h01; add_chunk(TAG_FMT, 16); add_chunk(TAG_DATA, 4);
    send_file();
    // Payload cut short by the end of file
    begin_file(); add_chunk(TAG_FMT, 16); add_word(TAG_DATA, 0); add_word(100, 1);
    add_body(3); send_file();
    // fmt short or missing, data empty or missing
    begin_file(); add_chunk(TAG_FMT, 15); add_chunk(TAG_DATA, 4); send_file();
    begin_file(); add_chunk(TAG_DATA, 4); send_file();
    begin_file(); add_chunk(TAG_FMT, 16); add_chunk(TAG_DATA, 0); send_file();
    begin_file(); add_chunk(TAG_FMT, 16); send_file();

    // Tightest legal limit: exactly twelve bytes pass the length check
    set_limit(27'd12);
    begin_file(); send_file();
    begin_file(); add_body(1); send_file();
    send_random_files(1);

    // Limit below the minimum, then the widest register value
    set_limit(27'd0);
    begin_file(); send_file();
    send_random_files(1);
    set_limit(27'h7FFFFFF);
    send_random_files(2);

    // Hold the result side so the output register fills and input stalls
    set_limit(MAX_BYTES_RESET);
    stall_req = 300;
    repeat (3) begin
      begin_file(); add_chunk(TAG_FMT, 16); add_chunk(TAG_DATA, 2); send_file();
    end
    drain();

    // Back to back with no idling on either side
    steady = 1;
    send_random_files(4);
    drain();
    steady = 0;

    // Random files across a mix of limits
    do begin
      case ($urandom_range(3))
        0: set_limit(27'($urandom_range(12, 120)));
        1: set_limit(MAX_BYTES_RESET);
        2: set_limit(27'($urandom));
        default: drain();
      endcase
      send_random_files($urandom_range(2, 4));
    end while (sent_bytes < 1000);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/wcl_pkg.sv
hw/rtl/wcl_in_reg.sv
hw/rtl/wcl_parser.sv
hw/rtl/wcl_out_reg.sv
hw/rtl/wave_chunk_locator.sv
hw/rtl/wcl_checker.sv
tb/wave_chunk_locator_tb.sv
